@@ rtl/network_block_read_engine_core_macros.svh @@
// Assertion macros used by the checker of the read engine.
// Depends on nothing; the using scope must provide clk and arst_n.
`ifndef NETWORK_BLOCK_READ_ENGINE_CORE_MACROS_SVH
`define NETWORK_BLOCK_READ_ENGINE_CORE_MACROS_SVH

// Overlapping implication, checked on every clock outside reset.
`define NBRE_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication into the next cycle.
`define NBRE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/nbre_pkg.sv @@
// Types, codes and constants of the network block read engine.
// Depends on nothing; used by the core and its checker.
package nbre_pkg;

	localparam int unsigned MAX_PAYLOAD_BYTES = 1408;
	localparam int unsigned MAX_CHUNK_SECTORS = 4;
	localparam int unsigned SECTOR_SHIFT      = 9;
	localparam int unsigned ALIGN_MASK        = 127;
	localparam int unsigned BLOCK_SHIFT       = 6;
	localparam int unsigned MAX_COPY_BLOCKS   = MAX_PAYLOAD_BYTES / 64;

	localparam int unsigned CHUNK_W = $clog2(MAX_CHUNK_SECTORS + 1);
	localparam int unsigned DUE_W   = CHUNK_W + SECTOR_SHIFT;
	localparam int unsigned OFF_W   = 25;
	localparam int unsigned BLK_W   = 5;
	localparam int unsigned TICK_W  = 24;
	localparam int unsigned RETRY_W = 4;

	localparam logic [TICK_W-1:0]  TICKS_RST = TICK_W'(1000000);
	localparam logic [RETRY_W-1:0] RETRY_RST = RETRY_W'(4);

	localparam int unsigned Q_DEPTH = 4;
	localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
	localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

	typedef enum logic [1:0] {
		CMD_DISCOVER = 2'd0,
		CMD_READ     = 2'd1,
		CMD_REPLY    = 2'd2,
		CMD_TICK     = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		RK_INFO  = 2'd0,
		RK_DATA  = 2'd1,
		RK_WRITE = 2'd2,
		RK_OTHER = 2'd3
	} reply_kind_t;

	typedef enum logic [2:0] {
		RES_SEND      = 3'd0,
		RES_COPY      = 3'd1,
		RES_DONE      = 3'd2,
		RES_FAILED    = 3'd3,
		RES_CONNECTED = 3'd4
	} result_kind_t;

	typedef enum logic [1:0] {
		ERR_NONE    = 2'd0,
		ERR_TIMEOUT = 2'd1,
		ERR_ORDER   = 2'd2,
		ERR_SIZE    = 2'd3
	} err_t;

	typedef enum logic {
		SEND_INFO = 1'b0,
		SEND_READ = 1'b1
	} send_kind_t;

	typedef enum logic {
		CFG_TICKS = 1'b0,
		CFG_RETRY = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		cmd_t        command;
		logic [31:0] read_sector;
		logic [15:0] read_count;
		reply_kind_t reply_kind;
		logic [7:0]  reply_id;
		logic [7:0]  reply_packet_index;
		logic [31:0] reply_param_one;
		logic [31:0] reply_param_two;
	} item_t;

	typedef struct packed {
		result_kind_t       kind;
		send_kind_t         send_kind;
		logic [7:0]         send_id;
		logic [31:0]        send_sector;
		logic [CHUNK_W-1:0] send_count;
		logic [OFF_W-1:0]   copy_offset;
		logic [BLK_W-1:0]   copy_blocks;
		err_t               error_code;
		logic [31:0]        disk_sector_size;
		logic [31:0]        disk_sector_count;
		logic               last;
	} result_t;

	function automatic logic [CHUNK_W-1:0] chunk_of(input logic [15:0] rem);
		if (rem > 16'(MAX_CHUNK_SECTORS))
			return CHUNK_W'(MAX_CHUNK_SECTORS);
		return rem[CHUNK_W-1:0];
	endfunction

endpackage

@@ rtl/network_block_read_engine_core.sv @@
// Requester side of a chunked sector read over datagrams.
// Depends on nbre_pkg.
//
// One beat enters per cycle while in_stall is low. A beat is held in an input
// register and handled there by one pass of compare/add logic plus the 3x24
// deadline multiplier and a constant multiply for the copy offset. Its results,
// at most two, land in a four-entry result queue, which drives the output. in_stall
// rises only while a beat waits in the input register and the queue has fewer
// than two free entries. The sustained rate is one beat per cycle when every beat
// yields one result and out_stall stays low. A beat that completes a chunk
// queues two results, and these drain one per cycle while out_stall is low.
module network_block_read_engine_core (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  command,
	input  logic [31:0] read_sector,
	input  logic [15:0] read_count,
	input  logic [1:0]  reply_kind,
	input  logic [7:0]  reply_id,
	input  logic [7:0]  reply_packet_index,
	input  logic [31:0] reply_param_one,
	input  logic [31:0] reply_param_two,

	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  result_kind,
	output logic        send_kind,
	output logic [7:0]  send_id,
	output logic [31:0] send_sector,
	output logic [2:0]  send_count,
	output logic [24:0] copy_offset,
	output logic [4:0]  copy_blocks,
	output logic [1:0]  error_code,
	output logic [31:0] disk_sector_size,
	output logic [31:0] disk_sector_count,
	output logic        last,

	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [23:0] cfg_data
);

	localparam int unsigned CW = nbre_pkg::CHUNK_W;
	localparam int unsigned DW = nbre_pkg::DUE_W;
	localparam int unsigned OW = nbre_pkg::OFF_W;
	localparam int unsigned PW = nbre_pkg::Q_PTR_W;
	localparam int unsigned NW = nbre_pkg::Q_CNT_W;
	localparam int unsigned MW = CW + 1 + nbre_pkg::TICK_W;

	// configuration
	logic [nbre_pkg::TICK_W-1:0]  ticks_q;
	logic [nbre_pkg::RETRY_W-1:0] retry_q;

	// read state
	logic          connected_q, active_q;
	logic [7:0]    rid_q;
	logic [31:0]   sector_q;
	logic [15:0]   rem_q;
	logic [CW-1:0] chunk_q;
	logic [DW-1:0] due_q;
	logic [7:0]    exp_q;
	logic [3:0]    failed_q;
	logic [31:0]   timer_q;
	logic [OW-1:0] base_q;

	logic          connected_n, active_n;
	logic [7:0]    rid_n;
	logic [31:0]   sector_n;
	logic [15:0]   rem_n;
	logic [CW-1:0] chunk_n;
	logic [DW-1:0] due_n;
	logic [7:0]    exp_n;
	logic [3:0]    failed_n;
	logic [31:0]   timer_n;
	logic [OW-1:0] base_n;

	// input stage
	nbre_pkg::item_t item_s1;
	logic            valid_s1;
	logic            accept, adv;

	// result queue
	nbre_pkg::result_t q_mem [nbre_pkg::Q_DEPTH];
	logic [PW-1:0]     rd_ptr_q, wr_ptr_q;
	logic [NW-1:0]     count_q;
	logic              pop;

	nbre_pkg::result_t r0, r1;
	logic [1:0]        n_res;

	// datapath terms
	logic [3:0]    fa_inc;
	logic          fail_final;
	logic          data_ok, order_bad, size_bad, chunk_done, complete;
	logic [DW-1:0] due_left;
	logic [15:0]   rem_after;
	logic [31:0]   sector_after;
	logic [OW-1:0] base_after;
	logic [OW-1:0] idx_m1, off_prod;
	logic [31:0]   timer_dec;
	logic          timeout;
	logic [CW-1:0] launch_chunk;
	logic [31:0]   launch_sector;
	logic [MW-1:0] deadline;
	logic          fail_req, launch_req, launch_hi;
	nbre_pkg::err_t fail_code;
	nbre_pkg::result_t launch_res;

	assign cfg_ready = 1'b1;

	assign pop      = out_valid && !out_stall;
	assign adv      = valid_s1 && (count_q <= NW'(nbre_pkg::Q_DEPTH - 2));
	assign in_stall = valid_s1 && !adv;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ticks_q <= nbre_pkg::TICKS_RST;
			retry_q <= nbre_pkg::RETRY_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (nbre_pkg::cfg_idx_t'(cfg_index))
				nbre_pkg::CFG_TICKS: ticks_q <= cfg_data;
				nbre_pkg::CFG_RETRY: retry_q <= cfg_data[nbre_pkg::RETRY_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (accept)
			valid_s1 <= 1'b1;
		else if (adv)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.command            <= nbre_pkg::cmd_t'(command);
			item_s1.read_sector        <= read_sector;
			item_s1.read_count         <= read_count;
			item_s1.reply_kind         <= nbre_pkg::reply_kind_t'(reply_kind);
			item_s1.reply_id           <= reply_id;
			item_s1.reply_packet_index <= reply_packet_index;
			item_s1.reply_param_one    <= reply_param_one;
			item_s1.reply_param_two    <= reply_param_two;
		end
	end

	// shared terms of the single pass
	assign fa_inc     = (failed_q == 4'hF) ? 4'hF : failed_q + 4'd1;
	assign fail_final = fa_inc >= retry_q;

	assign data_ok = (item_s1.reply_kind == nbre_pkg::RK_DATA) && active_q
		&& (32'(due_q) >= item_s1.reply_param_one) && (item_s1.reply_id == rid_q);
	assign order_bad = item_s1.reply_packet_index != exp_q;
	assign size_bad  = (item_s1.reply_param_one > 32'(nbre_pkg::MAX_PAYLOAD_BYTES))
		|| ((item_s1.reply_param_one & 32'(nbre_pkg::ALIGN_MASK)) != 32'd0);
	assign due_left   = due_q - item_s1.reply_param_one[DW-1:0];
	assign chunk_done = due_left == '0;
	assign complete   = (item_s1.command == nbre_pkg::CMD_REPLY) && data_ok
		&& !order_bad && !size_bad && chunk_done;

	assign rem_after    = rem_q - 16'(chunk_q);
	assign sector_after = sector_q + 32'(chunk_q);
	assign base_after   = base_q + OW'({chunk_q, {nbre_pkg::SECTOR_SHIFT{1'b0}}});

	assign idx_m1   = OW'(item_s1.reply_packet_index) - OW'(1);
	assign off_prod = idx_m1 * OW'(nbre_pkg::MAX_PAYLOAD_BYTES);

	assign timer_dec = (timer_q != 32'd0) ? timer_q - 32'd1 : 32'd0;
	assign timeout   = timer_dec == 32'd0;

	always_comb begin
		if (item_s1.command == nbre_pkg::CMD_READ) begin
			launch_chunk  = nbre_pkg::chunk_of(item_s1.read_count);
			launch_sector = item_s1.read_sector;
		end else if (complete) begin
			launch_chunk  = nbre_pkg::chunk_of(rem_after);
			launch_sector = sector_after;
		end else begin
			launch_chunk  = chunk_q;
			launch_sector = sector_q;
		end
	end

	assign deadline = (MW'(launch_chunk) + MW'(2)) * MW'(ticks_q);

	always_comb begin
		connected_n = connected_q;
		active_n    = active_q;
		rid_n       = rid_q;
		sector_n    = sector_q;
		rem_n       = rem_q;
		chunk_n     = chunk_q;
		due_n       = due_q;
		exp_n       = exp_q;
		failed_n    = failed_q;
		timer_n     = timer_q;
		base_n      = base_q;
		r0          = '0;
		r1          = '0;
		n_res       = 2'd0;
		fail_req    = 1'b0;
		fail_code   = nbre_pkg::ERR_NONE;
		launch_req  = 1'b0;
		launch_hi   = 1'b0;
		launch_res  = '0;

		case (item_s1.command)
			nbre_pkg::CMD_DISCOVER: begin
				r0.kind      = nbre_pkg::RES_SEND;
				r0.send_kind = nbre_pkg::SEND_INFO;
				r0.send_id   = rid_q;
				n_res        = 2'd1;
			end
			nbre_pkg::CMD_READ: begin
				sector_n = item_s1.read_sector;
				rem_n    = item_s1.read_count;
				base_n   = '0;
				n_res    = 2'd1;
				if (item_s1.read_count == 16'd0) begin
					active_n = 1'b0;
					r0.kind  = nbre_pkg::RES_DONE;
				end else begin
					active_n   = 1'b1;
					failed_n   = 4'd0;
					launch_req = 1'b1;
				end
			end
			nbre_pkg::CMD_REPLY: begin
				if (item_s1.reply_kind == nbre_pkg::RK_INFO) begin
					if (!connected_q) begin
						connected_n          = 1'b1;
						r0.kind              = nbre_pkg::RES_CONNECTED;
						r0.disk_sector_size  = item_s1.reply_param_one;
						r0.disk_sector_count = item_s1.reply_param_two;
						n_res                = 2'd1;
					end
				end else if (data_ok) begin
					n_res = 2'd1;
					if (order_bad) begin
						fail_req  = 1'b1;
						fail_code = nbre_pkg::ERR_ORDER;
					end else begin
						exp_n = exp_q + 8'd1;
						if (size_bad) begin
							fail_req  = 1'b1;
							fail_code = nbre_pkg::ERR_SIZE;
						end else begin
							r0.kind        = nbre_pkg::RES_COPY;
							r0.copy_offset = base_q + off_prod;
							r0.copy_blocks = item_s1.reply_param_one[nbre_pkg::BLOCK_SHIFT +:
								nbre_pkg::BLK_W];
							due_n = due_left;
							if (chunk_done) begin
								rem_n    = rem_after;
								sector_n = sector_after;
								base_n   = base_after;
								n_res    = 2'd2;
								if (rem_after == 16'd0) begin
									active_n = 1'b0;
									r1.kind  = nbre_pkg::RES_DONE;
								end else begin
									failed_n   = 4'd0;
									launch_req = 1'b1;
									launch_hi  = 1'b1;
								end
							end
						end
					end
				end
			end
			nbre_pkg::CMD_TICK: begin
				if (active_q) begin
					timer_n = timer_dec;
					if (timeout) begin
						n_res     = 2'd1;
						fail_req  = 1'b1;
						fail_code = nbre_pkg::ERR_TIMEOUT;
					end
				end
			end
			default: ;
		endcase

		if (fail_req) begin
			failed_n = fa_inc;
			if (fail_final) begin
				active_n      = 1'b0;
				connected_n   = 1'b0;
				r0            = '0;
				r0.kind       = nbre_pkg::RES_FAILED;
				r0.error_code = fail_code;
			end else begin
				launch_req = 1'b1;
			end
		end

		if (launch_req) begin
			rid_n   = rid_q + 8'd1;
			chunk_n = launch_chunk;
			due_n   = DW'({launch_chunk, {nbre_pkg::SECTOR_SHIFT{1'b0}}});
			exp_n   = 8'd1;
			timer_n = 32'(deadline);
			launch_res.kind        = nbre_pkg::RES_SEND;
			launch_res.send_kind   = nbre_pkg::SEND_READ;
			launch_res.send_id     = rid_q + 8'd1;
			launch_res.send_sector = launch_sector;
			launch_res.send_count  = launch_chunk;
			launch_res.error_code  = fail_code;
			if (launch_hi)
				r1 = launch_res;
			else
				r0 = launch_res;
		end

		if (n_res == 2'd2)
			r1.last = 1'b1;
		else
			r0.last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			connected_q <= 1'b0;
			active_q    <= 1'b0;
			rid_q       <= '0;
			sector_q    <= '0;
			rem_q       <= '0;
			chunk_q     <= '0;
			due_q       <= '0;
			exp_q       <= '0;
			failed_q    <= '0;
			timer_q     <= '0;
			base_q      <= '0;
		end else if (adv) begin
			connected_q <= connected_n;
			active_q    <= active_n;
			rid_q       <= rid_n;
			sector_q    <= sector_n;
			rem_q       <= rem_n;
			chunk_q     <= chunk_n;
			due_q       <= due_n;
			exp_q       <= exp_n;
			failed_q    <= failed_n;
			timer_q     <= timer_n;
			base_q      <= base_n;
		end
	end

	// result queue
	always_ff @(posedge clk) begin
		if (adv && n_res != 2'd0)
			q_mem[wr_ptr_q] <= r0;
		if (adv && n_res == 2'd2)
			q_mem[wr_ptr_q + PW'(1)] <= r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (adv)
				wr_ptr_q <= wr_ptr_q + PW'(n_res);
			if (pop)
				rd_ptr_q <= rd_ptr_q + PW'(1);
			count_q <= count_q + (adv ? NW'(n_res) : NW'(0)) - (pop ? NW'(1) : NW'(0));
		end
	end

	assign out_valid         = count_q != '0;
	assign result_kind       = q_mem[rd_ptr_q].kind;
	assign send_kind         = q_mem[rd_ptr_q].send_kind;
	assign send_id           = q_mem[rd_ptr_q].send_id;
	assign send_sector       = q_mem[rd_ptr_q].send_sector;
	assign send_count        = 3'(q_mem[rd_ptr_q].send_count);
	assign copy_offset       = q_mem[rd_ptr_q].copy_offset;
	assign copy_blocks       = q_mem[rd_ptr_q].copy_blocks;
	assign error_code        = q_mem[rd_ptr_q].error_code;
	assign disk_sector_size  = q_mem[rd_ptr_q].disk_sector_size;
	assign disk_sector_count = q_mem[rd_ptr_q].disk_sector_count;
	assign last              = q_mem[rd_ptr_q].last;

endmodule

@@ rtl/nbre_checker.sv @@
// Port-level checks on the read engine output, bound into the core.
// Depends on nbre_pkg and network_block_read_engine_core_macros.svh.
`include "network_block_read_engine_core_macros.svh"

module nbre_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [2:0]  result_kind,
	input logic        send_kind,
	input logic [2:0]  send_count,
	input logic [4:0]  copy_blocks,
	input logic [1:0]  error_code,
	input logic        last
);

	`NBRE_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result beat dropped while stalled")

	`NBRE_ASSERT_NOW(a_copy_size, out_valid && result_kind == nbre_pkg::RES_COPY, copy_blocks <= 5'(nbre_pkg::MAX_COPY_BLOCKS) && error_code == nbre_pkg::ERR_NONE, "bad copy beat")

	`NBRE_ASSERT_NOW(a_read_count, out_valid && result_kind == nbre_pkg::RES_SEND && send_kind == nbre_pkg::SEND_READ, send_count != 3'd0 && send_count <= 3'(nbre_pkg::MAX_CHUNK_SECTORS), "read request with bad sector count")

	`NBRE_ASSERT_NOW(a_single_last, out_valid && (result_kind == nbre_pkg::RES_CONNECTED || result_kind == nbre_pkg::RES_FAILED), last, "single result not marked last")

endmodule

bind network_block_read_engine_core nbre_checker u_nbre_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.result_kind (result_kind),
	.send_kind   (send_kind),
	.send_count  (send_count),
	.copy_blocks (copy_blocks),
	.error_code  (error_code),
	.last        (last)
);

@@ tb/sv/tb_network_block_read_engine_core.sv @@
// Testbench for network_block_read_engine_core: a directed table and random beats.
// Results are checked against a read engine model in this file or a typed row.
// Depends on nbre_pkg and the core RTL.
`timescale 1ns / 100ps

module tb_network_block_read_engine_core;
	import nbre_pkg::*;

	localparam int QUIET_LIMIT = 2000;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  command;
	logic [31:0] read_sector;
	logic [15:0] read_count;
	logic [1:0]  reply_kind;
	logic [7:0]  reply_id;
	logic [7:0]  reply_packet_index;
	logic [31:0] reply_param_one;
	logic [31:0] reply_param_two;
	logic        out_valid;
	logic        out_stall;
	logic [2:0]  result_kind;
	logic        send_kind;
	logic [7:0]  send_id;
	logic [31:0] send_sector;
	logic [2:0]  send_count;
	logic [24:0] copy_offset;
	logic [4:0]  copy_blocks;
	logic [1:0]  error_code;
	logic [31:0] disk_sector_size;
	logic [31:0] disk_sector_count;
	logic        last;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_index;
	logic [23:0] cfg_data;

	network_block_read_engine_core dut (.*);

	typedef struct {
		bit          reg_write;
		cfg_idx_t    reg_sel;
		logic [23:0] reg_val;
		item_t       stim;
		bit          typed;
		result_t     want;
	} plan_row_t;

	result_t     results_in_flight[$];
	int          faults = 0;
	bit          send_calm = 1'b0;

	logic        link_up = 1'b0;
	logic        reading = 1'b0;
	logic [7:0]  cur_id = '0;
	logic [31:0] next_sector = '0;
	logic [15:0] left_sectors = '0;
	logic [2:0]  chunk_len = '0;
	logic [11:0] bytes_owed = '0;
	logic [7:0]  want_index = '0;
	logic [3:0]  fails = '0;
	logic [31:0] timer_left = '0;
	logic [24:0] buf_base = '0;
	logic [23:0] unit_ticks = TICKS_RST;
	logic [3:0]  retries = RETRY_RST;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic void launch_try(output result_t r);
		cur_id        = cur_id + 8'd1;
		bytes_owed    = 12'(chunk_len) << SECTOR_SHIFT;
		want_index    = 8'd1;
		timer_left    = (32'(chunk_len) + 32'd2) * 32'(unit_ticks);
		r             = '0;
		r.kind        = RES_SEND;
		r.send_kind   = SEND_READ;
		r.send_id     = cur_id;
		r.send_sector = next_sector;
		r.send_count  = chunk_len;
	endfunction

	function automatic void open_chunk(output result_t r);
		chunk_len = (left_sectors > 16'(MAX_CHUNK_SECTORS)) ? 3'(MAX_CHUNK_SECTORS)
			: left_sectors[2:0];
		fails = '0;
		launch_try(r);
	endfunction

	function automatic void fail_try(input err_t code, output result_t r);
		if (fails != 4'd15)
			fails = fails + 4'd1;
		if (fails >= retries) begin
			reading = 1'b0;
			link_up = 1'b0;
			r = '0;
			r.kind = RES_FAILED;
		end else begin
			launch_try(r);
		end
		r.error_code = code;
	endfunction

	function automatic int engine_react(input item_t it);
		result_t     r[2];
		int          n;
		logic [31:0] off;
		r[0] = '0;
		r[1] = '0;
		n = 0;
		case (it.command)
			CMD_DISCOVER: begin
				r[0].kind      = RES_SEND;
				r[0].send_kind = SEND_INFO;
				r[0].send_id   = cur_id;
				n = 1;
			end
			CMD_READ: begin
				next_sector  = it.read_sector;
				left_sectors = it.read_count;
				buf_base     = '0;
				reading      = (it.read_count != 16'd0);
				if (reading)
					open_chunk(r[0]);
				else
					r[0].kind = RES_DONE;
				n = 1;
			end
			CMD_REPLY: begin
				if (it.reply_kind == RK_INFO) begin
					if (!link_up) begin
						link_up   = 1'b1;
						r[0].kind = RES_CONNECTED;
						r[0].disk_sector_size  = it.reply_param_one;
						r[0].disk_sector_count = it.reply_param_two;
						n = 1;
					end
				end else if (it.reply_kind == RK_DATA && reading && it.reply_id == cur_id
						&& 32'(bytes_owed) >= it.reply_param_one) begin
					n = 1;
					if (it.reply_packet_index != want_index) begin
						fail_try(ERR_ORDER, r[0]);
					end else begin
						want_index = want_index + 8'd1;
						if (it.reply_param_one > MAX_PAYLOAD_BYTES
								|| (it.reply_param_one & ALIGN_MASK) != 0) begin
							fail_try(ERR_SIZE, r[0]);
						end else begin
							off = 32'(buf_base)
								+ (32'(it.reply_packet_index) - 32'd1) * MAX_PAYLOAD_BYTES;
							r[0].kind        = RES_COPY;
							r[0].copy_offset = off[24:0];
							r[0].copy_blocks = 5'(it.reply_param_one >> BLOCK_SHIFT);
							bytes_owed = bytes_owed - it.reply_param_one[11:0];
							if (bytes_owed == '0) begin
								left_sectors = left_sectors - 16'(chunk_len);
								next_sector  = next_sector + 32'(chunk_len);
								buf_base     = buf_base + (25'(chunk_len) << SECTOR_SHIFT);
								n = 2;
								if (left_sectors == '0) begin
									reading   = 1'b0;
									r[1].kind = RES_DONE;
								end else begin
									open_chunk(r[1]);
								end
							end
						end
					end
				end
			end
			default: begin
				if (reading) begin
					if (timer_left != '0)
						timer_left = timer_left - 32'd1;
					if (timer_left == '0) begin
						fail_try(ERR_TIMEOUT, r[0]);
						n = 1;
					end
				end
			end
		endcase
		for (int k = 0; k < n; k++) begin
			r[k].last = (k == n - 1);
			results_in_flight.push_back(r[k]);
		end
		return n;
	endfunction

	function automatic item_t beat_of(input cmd_t c, input logic [31:0] sec,
			input logic [15:0] cnt, input reply_kind_t k, input logic [7:0] id,
			input logic [7:0] idx, input logic [31:0] p1, input logic [31:0] p2);
		item_t it;
		it.command            = c;
		it.read_sector        = sec;
		it.read_count         = cnt;
		it.reply_kind         = k;
		it.reply_id           = id;
		it.reply_packet_index = idx;
		it.reply_param_one    = p1;
		it.reply_param_two    = p2;
		return it;
	endfunction

	function automatic result_t result_of(input result_kind_t k, input logic [7:0] id,
			input err_t e, input logic [31:0] sz, input logic [31:0] ct);
		result_t r;
		r = '0;
		r.kind              = k;
		r.send_id           = id;
		r.error_code        = e;
		r.disk_sector_size  = sz;
		r.disk_sector_count = ct;
		r.last              = 1'b1;
		return r;
	endfunction

	function automatic plan_row_t cfg_row(input cfg_idx_t sel, input logic [23:0] val);
		plan_row_t p;
		p = '{1'b1, sel, val, item_t'('0), 1'b0, result_t'('0)};
		return p;
	endfunction

	function automatic plan_row_t stim_row(input item_t it);
		plan_row_t p;
		p = '{1'b0, CFG_TICKS, 24'd0, it, 1'b0, result_t'('0)};
		return p;
	endfunction

	function automatic plan_row_t typed_row(input item_t it, input result_t want);
		plan_row_t p;
		p = '{1'b0, CFG_TICKS, 24'd0, it, 1'b1, want};
		return p;
	endfunction

	// Mostly well-formed traffic steered by the model state, plus some noise.
	function automatic item_t forge_beat();
		item_t       it;
		int          roll;
		logic [11:0] room;
		it = beat_of(cmd_t'($urandom_range(0, 3)), $urandom, 16'($urandom),
			reply_kind_t'($urandom_range(0, 3)), 8'($urandom), 8'($urandom),
			$urandom, $urandom);
		roll = $urandom_range(0, 99);
		room = (bytes_owed > 12'(MAX_PAYLOAD_BYTES)) ? 12'(MAX_PAYLOAD_BYTES) : bytes_owed;
		if (roll < 70 && reading) begin
			it.command            = CMD_REPLY;
			it.reply_kind         = RK_DATA;
			it.reply_id           = cur_id;
			it.reply_packet_index = want_index;
			it.reply_param_one    = 32'(128 * $urandom_range(0, room / 128));
			if (roll < 8)
				it.reply_packet_index = want_index + 8'($urandom_range(1, 255));
			else if (roll < 14)
				it.reply_param_one = $urandom_range(0, bytes_owed);
			else if (roll < 18)
				it.reply_id = cur_id + 8'($urandom_range(1, 255));
			else if (roll < 20)
				it.reply_param_one = 32'(bytes_owed) + $urandom_range(1, 4096);
			else if (roll < 22)
				it.reply_param_one = $urandom;
		end else if (roll < 82 && reading) begin
			it.command = CMD_TICK;
		end else if (roll < 88 || (roll < 70 && !reading)) begin
			it.command = CMD_READ;
			case ($urandom_range(0, 9))
				0: it.read_count = 16'd0;
				1: it.read_count = 16'hFFFF;
				2: ;
				default: it.read_count = 16'($urandom_range(1, 12));
			endcase
		end else if (roll < 92) begin
			it.command = CMD_DISCOVER;
		end else if (roll < 96) begin
			it.command    = CMD_REPLY;
			it.reply_kind = RK_INFO;
		end
		return it;
	endfunction

	task automatic offer_beat(input item_t it, output int produced);
		int gap;
		gap = send_calm ? 0 : $urandom_range(0, 11);
		if ($urandom_range(0, 39) == 0)
			send_calm = !send_calm;
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		command            = it.command;
		read_sector        = it.read_sector;
		read_count         = it.read_count;
		reply_kind         = it.reply_kind;
		reply_id           = it.reply_id;
		reply_packet_index = it.reply_packet_index;
		reply_param_one    = it.reply_param_one;
		reply_param_two    = it.reply_param_two;
		in_valid           = 1'b1;
		do
			@(posedge clk);
		while (in_stall);
		produced = engine_react(it);
		@(negedge clk);
	endtask

	task automatic write_register(input cfg_idx_t sel, input logic [23:0] val);
		in_valid = 1'b0;
		while (results_in_flight.size() != 0)
			@(negedge clk);
		repeat (6) @(negedge clk);
		cfg_index = sel;
		cfg_data  = val;
		cfg_valid = 1'b1;
		do
			@(posedge clk);
		while (!cfg_ready);
		if (sel == CFG_TICKS)
			unit_ticks = val;
		else
			retries = val[3:0];
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic check_result(input result_t w);
		if (result_kind !== w.kind) begin
			$error("result_kind: expected %0d, got %0d", w.kind, result_kind);
			faults++;
		end
		if (send_kind !== w.send_kind) begin
			$error("send_kind: expected %0d, got %0d", w.send_kind, send_kind);
			faults++;
		end
		if (send_id !== w.send_id) begin
			$error("send_id: expected %0d, got %0d", w.send_id, send_id);
			faults++;
		end
		if (send_sector !== w.send_sector) begin
			$error("send_sector: expected %0h, got %0h", w.send_sector, send_sector);
			faults++;
		end
		if (send_count !== w.send_count) begin
			$error("send_count: expected %0d, got %0d", w.send_count, send_count);
			faults++;
		end
		if (copy_offset !== w.copy_offset) begin
			$error("copy_offset: expected %0h, got %0h", w.copy_offset, copy_offset);
			faults++;
		end
		if (copy_blocks !== w.copy_blocks) begin
			$error("copy_blocks: expected %0d, got %0d", w.copy_blocks, copy_blocks);
			faults++;
		end
		if (error_code !== w.error_code) begin
			$error("error_code: expected %0d, got %0d", w.error_code, error_code);
			faults++;
		end
		if (disk_sector_size !== w.disk_sector_size) begin
			$error("disk_sector_size: expected %0h, got %0h", w.disk_sector_size,
				disk_sector_size);
			faults++;
		end
		if (disk_sector_count !== w.disk_sector_count) begin
			$error("disk_sector_count: expected %0h, got %0h", w.disk_sector_count,
				disk_sector_count);
			faults++;
		end
		if (last !== w.last) begin
			$error("last: expected %0d, got %0d", w.last, last);
			faults++;
		end
	endtask

	// Result side; one long hold-off lets the core fill up and stall its input.
	initial begin
		result_t w;
		int      hold;
		int      taken;
		bit      calm;
		taken = 0;
		calm = 1'b0;
		out_stall = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			hold = calm ? 0 : $urandom_range(0, 11);
			if ($urandom_range(0, 39) == 0)
				calm = !calm;
			if (taken == 150)
				hold = 300;
			if (hold > 0) begin
				out_stall = 1'b1;
				repeat (hold) @(negedge clk);
				out_stall = 1'b0;
			end
			do
				@(posedge clk);
			while (!out_valid);
			taken++;
			if (results_in_flight.size() == 0) begin
				$error("result_kind: expected none, got %0d", result_kind);
				faults++;
			end else begin
				w = results_in_flight.pop_front();
				check_result(w);
			end
			@(negedge clk);
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		wait (arst_n === 1'b1);
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("** network_block_read_engine_core: FAILED **");
		$finish;
	end

	initial begin
		plan_row_t   plan[$];
		int          produced;
		int          useful;
		logic [23:0] tick_val;
		logic [23:0] retry_val;
		arst_n             = 1'b0;
		in_valid           = 1'b0;
		command            = CMD_DISCOVER;
		read_sector        = '0;
		read_count         = '0;
		reply_kind         = RK_INFO;
		reply_id           = '0;
		reply_packet_index = '0;
		reply_param_one    = '0;
		reply_param_two    = '0;
		cfg_valid          = 1'b0;
		cfg_index          = CFG_TICKS;
		cfg_data           = '0;

		plan.push_back(cfg_row(CFG_TICKS, 24'd1));
		plan.push_back(cfg_row(CFG_RETRY, 24'd2));
		plan.push_back(typed_row(beat_of(CMD_DISCOVER, 0, 0, RK_INFO, 0, 0, 0, 0),
			result_of(RES_SEND, 8'd0, ERR_NONE, 0, 0)));
		plan.push_back(typed_row(beat_of(CMD_REPLY, 0, 0, RK_INFO, 0, 0, 512, 32'hFFFFFFFF),
			result_of(RES_CONNECTED, 8'd0, ERR_NONE, 512, 32'hFFFFFFFF)));
		plan.push_back(stim_row(beat_of(CMD_REPLY, 0, 0, RK_INFO, 0, 0, 0, 0)));
		plan.push_back(typed_row(beat_of(CMD_READ, 32'hFFFFFFFF, 0, RK_INFO, 0, 0, 0, 0),
			result_of(RES_DONE, 8'd0, ERR_NONE, 0, 0)));
		plan.push_back(stim_row(beat_of(CMD_TICK, 0, 0, RK_INFO, 0, 0, 0, 0)));
		plan.push_back(stim_row(beat_of(CMD_READ, 32'hFFFFFFFE, 6, RK_INFO, 0, 0, 0, 0)));
		plan.push_back(stim_row(beat_of(CMD_REPLY, 0, 0, RK_WRITE, 1, 1, 128, 0)));
		plan.push_back(stim_row(beat_of(CMD_REPLY, 0, 0, RK_OTHER, 1, 1, 128, 0)));
		plan.push_back(stim_row(beat_of(CMD_REPLY, 0, 0, RK_DATA, 0, 1, 128, 0)));
		plan.push_back(stim_row(beat_of(CMD_REPLY, 0, 0, RK_DATA, 1, 1, 0, 0)));
		plan.push_back(stim_row(beat_of(CMD_REPLY, 0, 0, RK_DATA, 1, 2, 1408, 0)));
		plan.push_back(stim_row(beat_of(CMD_REPLY, 0, 0, RK_DATA, 1, 3, 4096, 0)));
		plan.push_back(stim_row(beat_of(CMD_REPLY, 0, 0, RK_DATA, 1, 3, 640, 0)));
		plan.push_back(stim_row(beat_of(CMD_REPLY, 0, 0, RK_DATA, 2, 5, 128, 0)));
		plan.push_back(typed_row(beat_of(CMD_REPLY, 0, 0, RK_DATA, 3, 1, 100, 0),
			result_of(RES_FAILED, 8'd0, ERR_SIZE, 0, 0)));
		plan.push_back(typed_row(beat_of(CMD_REPLY, 0, 0, RK_INFO, 0, 0, 32'hFFFFFFFF, 0),
			result_of(RES_CONNECTED, 8'd0, ERR_NONE, 32'hFFFFFFFF, 0)));
		plan.push_back(stim_row(beat_of(CMD_READ, 0, 16'hFFFF, RK_INFO, 0, 0, 0, 0)));
		plan.push_back(stim_row(beat_of(CMD_REPLY, 0, 0, RK_DATA, 4, 1, 1536, 0)));
		repeat (6)
			plan.push_back(stim_row(beat_of(CMD_TICK, 0, 0, RK_INFO, 0, 0, 0, 0)));
		plan.push_back(cfg_row(CFG_TICKS, 24'd0));
		plan.push_back(cfg_row(CFG_RETRY, 24'd0));
		plan.push_back(stim_row(beat_of(CMD_READ, 5, 1, RK_INFO, 0, 0, 0, 0)));
		plan.push_back(typed_row(beat_of(CMD_TICK, 0, 0, RK_INFO, 0, 0, 0, 0),
			result_of(RES_FAILED, 8'd0, ERR_TIMEOUT, 0, 0)));

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (plan[i]) begin
			if (plan[i].reg_write) begin
				write_register(plan[i].reg_sel, plan[i].reg_val);
			end else begin
				offer_beat(plan[i].stim, produced);
				if (plan[i].typed) begin
					void'(results_in_flight.pop_back());
					results_in_flight.push_back(plan[i].want);
				end
			end
		end

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					tick_val  = 24'd3;
					retry_val = 24'd3;
				end
				1: begin
					tick_val  = 24'hFFFFFF;
					retry_val = 24'd15;
				end
				2: begin
					tick_val  = 24'd1;
					retry_val = 24'd1;
				end
				default: begin
					tick_val  = 24'($urandom_range(1, 8));
					retry_val = 24'($urandom_range(1, 15));
				end
			endcase
			write_register(CFG_TICKS, tick_val);
			write_register(CFG_RETRY, retry_val);
			if (ph == 1) begin
				// long run of empty beats: packet index and copy offset wrap
				offer_beat(beat_of(CMD_READ, $urandom, 4, RK_INFO, 0, 0, 0, 0), produced);
				repeat (260)
					offer_beat(beat_of(CMD_REPLY, 0, 0, RK_DATA, cur_id, want_index, 0, 0),
						produced);
			end
			useful = 0;
			while (useful < 30) begin
				offer_beat(forge_beat(), produced);
				if (produced > 0)
					useful++;
			end
		end

		in_valid = 1'b0;
		while (results_in_flight.size() != 0)
			@(negedge clk);
		repeat (8) @(posedge clk);
		if (faults == 0)
			$display("** network_block_read_engine_core: PASSED **");
		else
			$display("** network_block_read_engine_core: FAILED **");
		$finish;
	end

endmodule
